/* hw/rtl/pwfs_pkg.sv */
// Package for the per-pixel Welford statistics core: sizes, formats, lane types.
// No dependencies.
`default_nettype none
package pwfs_pkg;
    localparam int IMG_WIDTH = 64;
    localparam int IMG_HEIGHT = 64;
    localparam int CHANNELS_PER_FEATURE = 3;
    localparam int FEATURES = 4;
    localparam int NPIX = IMG_WIDTH * IMG_HEIGHT;
    localparam int NCH = FEATURES * CHANNELS_PER_FEATURE;
    localparam int PIX_W = $clog2(NPIX);
    localparam int CNT_W = 16;
    localparam int MEAN_W = 24;
    localparam int M2_W = 40;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_SETC  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Operation handed from the sequencer to each lane.
    typedef struct packed {
        mode_t               mode;
        logic [CNT_W-1:0]    n;
    } lane_op_t;
endpackage
`default_nettype wire

/* hw/rtl/pwfs_div.sv */
// Radix-2 restoring divider shared by the lane update and the variance output.
// Depends on pwfs_pkg.
`default_nettype none
module pwfs_div
    import pwfs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [M2_W+1:0]     dividend,
    input  wire logic [M2_W+1:0]     divisor,
    output logic                     done,
    output logic [M2_W+1:0]          quotient
);
    localparam int W = M2_W + 2;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb begin
        shifted = {r_reg[W-1:0], q_reg[W-1]};
        trial = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= dividend;
                d_reg    <= divisor;
                r_reg    <= '0;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    r_reg <= trial;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end else begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

/* hw/rtl/pwfs_lane.sv */
// One channel lane: Welford update of mean and M2 with its own divider.
// Depends on pwfs_pkg and pwfs_div.
`default_nettype none
module pwfs_lane
    import pwfs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire lane_op_t               op,
    input  wire logic                   set_en,
    input  wire logic [15:0]            sample,
    input  wire logic [MEAN_W-1:0]      mean_in,
    input  wire logic [M2_W-1:0]        m2_in,
    output logic                        done,
    output logic [MEAN_W-1:0]           mean_out,
    output logic [M2_W-1:0]             m2_out,
    output logic [15:0]                 var_out
);
    localparam int W = M2_W + 2;
    typedef enum logic [2:0] {S_IDLE, S_DIVD, S_MUL, S_DIVV, S_DONE} st_t;
    st_t st_reg;

    logic signed [25:0] x_reg, d_reg, nm_reg;
    logic        [M2_W-1:0] m2_reg;
    logic        [M2_W-1:0] m2_sum_hold;
    logic        [MEAN_W-1:0] mean_reg;
    logic        [CNT_W-1:0]  n_reg;
    mode_t       mode_reg;
    logic        set_reg;
    logic        [15:0] var_reg;
    logic        done_reg;

    logic        dv_start;
    logic [W-1:0] dv_a, dv_b, dv_q;
    logic        dv_done;

    pwfs_div u_div (
        .aclk, .aresetn, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
        .done(dv_done), .quotient(dv_q)
    );

    logic signed [25:0] x_in, d_in;
    logic [25:0] d_in_abs;
    logic [25:0] dabs;
    logic signed [26:0] e_s;
    logic [25:0] eabs;
    logic [51:0] prod;
    logic [M2_W:0] m2_sum;
    logic signed [25:0] qsig;
    logic [CNT_W-1:0] nm1;

    always_comb begin
        x_in = 26'($signed(sample)) <<< 8;
        d_in = x_in - 26'($signed(mean_in));
        d_in_abs = d_in[25] ? 26'(-d_in) : 26'(d_in);
        dabs = d_reg[25] ? 26'(-d_reg) : 26'(d_reg);
        qsig = d_reg[25] ? -$signed(dv_q[25:0]) : $signed(dv_q[25:0]);
        e_s = 27'(x_reg) - 27'(nm_reg);
        eabs = e_s[26] ? 26'(-e_s) : 26'(e_s);
        prod = dabs * eabs;
        m2_sum = {1'b0, m2_reg} + (M2_W+1)'(prod[51:16]);
        nm1 = n_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            done_reg <= 1'b0;
            dv_start <= 1'b0;
        end else begin
            dv_start <= 1'b0;
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (start) begin
                    n_reg <= op.n;
                    mode_reg <= op.mode;
                    set_reg <= set_en;
                    x_reg <= x_in;
                    d_reg <= d_in;
                    nm_reg <= 26'($signed(mean_in));
                    mean_reg <= mean_in;
                    m2_reg <= m2_in;
                    if (op.mode == MODE_ADD) begin
                        st_reg <= S_DIVD;
                        dv_start <= 1'b1;
                        // divide the magnitude of d, sign goes back on afterwards
                        dv_a <= W'(d_in_abs);
                        dv_b <= W'(op.n);
                    end else st_reg <= S_MUL;
                end
                S_DIVD: begin
                    if (dv_done) begin
                        nm_reg <= nm_reg + qsig;
                        st_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mode_reg == MODE_ADD) begin
                        m2_reg <= m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
                        mean_reg <= nm_reg[MEAN_W-1:0];
                        m2_sum_hold <= m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
                    end else if (mode_reg == MODE_SETC && set_reg) begin
                        mean_reg <= x_reg[MEAN_W-1:0];
                        m2_sum_hold <= m2_reg;
                    end else if (mode_reg == MODE_CLEAR) begin
                        mean_reg <= '0;
                        m2_reg <= '0;
                        m2_sum_hold <= '0;
                    end else m2_sum_hold <= m2_reg;
                    if (n_reg >= CNT_W'(2) && mode_reg != MODE_CLEAR) begin
                        st_reg <= S_DIVV;
                        dv_start <= 1'b1;
                        dv_a <= W'(mode_reg == MODE_ADD ?
                                   (m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0]) : m2_reg);
                        dv_b <= W'({nm1, 8'h00});
                    end else begin
                        var_reg <= '0;
                        st_reg <= S_DONE;
                    end
                end
                S_DIVV: if (dv_done) begin
                    var_reg <= (dv_q > W'(16'hFFFF)) ? 16'hFFFF : dv_q[15:0];
                    st_reg <= S_DONE;
                end
                S_DONE: begin
                    done_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign mean_out = mean_reg;
    assign m2_out = m2_sum_hold;
    assign var_out = var_reg;
endmodule
`default_nettype wire

/* hw/rtl/per_pixel_welford_stats_core.sv */
// Top level of the per-pixel Welford statistics core: store, sequencer, lanes, merge.
// Depends on pwfs_pkg and pwfs_lane.
//
//   channel  direction  beat contents
//   s_       in         mode, pixel_x, pixel_y, four packed sample groups
//   m_       out        sample_count, four mean groups, four variance groups
//
// Each in-range beat reads the pixel's count and twelve channel entries from memories,
// runs all twelve lanes in parallel (each with a bit-serial divider for d/n and
// for M2/(n-1)), writes back, and merges lane results into the output register;
// an out-of-range beat returns zeros. An add runs the d/n divider, then the M2/(n-1)
// one if it leaves two or more samples; a read or color set runs only the M2/(n-1)
// divider, and only at two or more samples; a clear runs neither. The next beat is
// taken the cycle after the result is.
// After reset a clearing pass sweeps all 4096 rows of the store; no beat is taken meanwhile.
// The result holds in the output register until taken; the next beat waits.
`default_nettype none
module per_pixel_welford_stats_core
    import pwfs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_mode,
    input  wire logic [5:0]   s_pixel_x,
    input  wire logic [5:0]   s_pixel_y,
    input  wire logic [47:0]  s_color_sample,
    input  wire logic [47:0]  s_normal_sample,
    input  wire logic [47:0]  s_texture_sample,
    input  wire logic [47:0]  s_depth_sample,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_sample_count,
    output logic [47:0]       m_color_mean,
    output logic [47:0]       m_normal_mean,
    output logic [47:0]       m_texture_mean,
    output logic [47:0]       m_depth_mean,
    output logic [47:0]       m_color_var,
    output logic [47:0]       m_normal_var,
    output logic [47:0]       m_texture_var,
    output logic [47:0]       m_depth_var
);
    typedef enum logic [2:0] {T_CLR, T_IDLE, T_RD, T_RUN, T_WB, T_OUT} st_t;
    st_t st_reg;

    // stores: one row per pixel
    logic [CNT_W-1:0]        cnt_mem  [NPIX];
    logic [NCH*MEAN_W-1:0]   mean_mem [NPIX];
    logic [NCH*M2_W-1:0]     m2_mem   [NPIX];

    logic [PIX_W-1:0]        addr_reg;
    logic [PIX_W:0]          clr_reg;
    logic [CNT_W-1:0]        cnt_rd_reg;
    logic [NCH*MEAN_W-1:0]   mean_rd_reg;
    logic [NCH*M2_W-1:0]     m2_rd_reg;
    mode_t                   mode_reg;
    logic [4*48-1:0]         samp_reg;
    logic                    oob_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        n_next;

    logic                    lane_start_reg;
    lane_op_t                op;
    logic [NCH-1:0]          lane_done;
    logic [NCH-1:0]          done_seen_reg;
    logic [MEAN_W-1:0]       lmean [NCH];
    logic [M2_W-1:0]         lm2   [NCH];
    logic [15:0]             lvar  [NCH];

    logic [15:0]             o_cnt_reg;
    logic [4*48-1:0]         o_mean_reg, o_var_reg;
    logic                    m_valid_reg;

    assign op.mode = mode_reg;
    assign op.n = n_next;

    for (genvar k = 0; k < NCH; k++) begin : g_lane
        localparam int F = k / CHANNELS_PER_FEATURE;
        localparam int C = k % CHANNELS_PER_FEATURE;
        pwfs_lane u_lane (
            .aclk, .aresetn,
            .start(lane_start_reg), .op(op), .set_en(F == 0),
            .sample(samp_reg[F*48 + C*16 +: 16]),
            .mean_in(mean_rd_reg[k*MEAN_W +: MEAN_W]),
            .m2_in(m2_rd_reg[k*M2_W +: M2_W]),
            .done(lane_done[k]), .mean_out(lmean[k]), .m2_out(lm2[k]), .var_out(lvar[k])
        );
    end

    // merge lane results into packed groups
    logic [NCH*MEAN_W-1:0] wb_mean;
    logic [NCH*M2_W-1:0]   wb_m2;
    logic [4*48-1:0]       mg_mean, mg_var;
    always_comb begin
        mg_mean = '0;
        mg_var = '0;
        for (int k = 0; k < NCH; k++) begin
            wb_mean[k*MEAN_W +: MEAN_W] = lmean[k];
            wb_m2[k*M2_W +: M2_W] = lm2[k];
            mg_mean[(k/CHANNELS_PER_FEATURE)*48 + (k%CHANNELS_PER_FEATURE)*16 +: 16] =
                lmean[k][23:8];
            mg_var[(k/CHANNELS_PER_FEATURE)*48 + (k%CHANNELS_PER_FEATURE)*16 +: 16] =
                lvar[k];
        end
    end

    logic in_fire;
    assign in_fire = s_valid && s_ready;
    assign s_ready = (st_reg == T_IDLE);

    always_ff @(posedge aclk) begin
        if (st_reg == T_CLR) begin
            cnt_mem[clr_reg[PIX_W-1:0]]  <= '0;
            mean_mem[clr_reg[PIX_W-1:0]] <= '0;
            m2_mem[clr_reg[PIX_W-1:0]]   <= '0;
        end else if (st_reg == T_WB) begin
            cnt_mem[addr_reg]  <= n_reg;
            mean_mem[addr_reg] <= wb_mean;
            m2_mem[addr_reg]   <= wb_m2;
        end
        cnt_rd_reg  <= cnt_mem[addr_reg];
        mean_rd_reg <= mean_mem[addr_reg];
        m2_rd_reg   <= m2_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= T_CLR;
            clr_reg <= '0;
            mode_reg <= MODE_READ;
            m_valid_reg <= 1'b0;
            lane_start_reg <= 1'b0;
            done_seen_reg <= '0;
        end else begin
            // launch lanes the cycle read data lands
            lane_start_reg <= (st_reg == T_RD) && !oob_reg;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (st_reg)
                T_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (PIX_W+1)'(NPIX - 1)) st_reg <= T_IDLE;
                end
                T_IDLE: if (in_fire) begin
                    mode_reg <= mode_t'(s_mode);
                    samp_reg <= {s_depth_sample, s_texture_sample,
                                 s_normal_sample, s_color_sample};
                    oob_reg <= (32'(s_pixel_x) >= IMG_WIDTH) ||
                               (32'(s_pixel_y) >= IMG_HEIGHT);
                    addr_reg <= PIX_W'(32'(s_pixel_y) * IMG_WIDTH + 32'(s_pixel_x));
                    st_reg <= T_RD;
                end
                T_RD: st_reg <= T_RUN;  // wait for registered read
                T_RUN: begin
                    if (oob_reg) begin
                        o_cnt_reg <= '0;
                        o_mean_reg <= '0;
                        o_var_reg <= '0;
                        m_valid_reg <= 1'b1;
                        st_reg <= T_OUT;
                    end else if ((done_seen_reg | lane_done) == {NCH{1'b1}}) begin
                        done_seen_reg <= '0;
                        st_reg <= T_WB;
                    end else begin
                        done_seen_reg <= done_seen_reg | lane_done;
                    end
                end
                T_WB: begin
                    o_cnt_reg <= n_reg;
                    o_mean_reg <= mg_mean;
                    o_var_reg <= mg_var;
                    m_valid_reg <= 1'b1;
                    st_reg <= T_OUT;
                end
                T_OUT: if (m_valid_reg && m_ready) st_reg <= T_IDLE;
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    // count for this beat, from the registered read count
    always_comb begin
        unique case (mode_reg)
            MODE_ADD:   n_next = (cnt_rd_reg == COUNT_MAX) ? COUNT_MAX : cnt_rd_reg + 1'b1;
            MODE_CLEAR: n_next = '0;
            default:    n_next = cnt_rd_reg;
        endcase
    end

    // hold the count for write-back and output
    always_ff @(posedge aclk) begin
        if (st_reg == T_RUN) begin
            n_reg <= n_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sample_count = o_cnt_reg;
    assign m_color_mean   = o_mean_reg[47:0];
    assign m_normal_mean  = o_mean_reg[95:48];
    assign m_texture_mean = o_mean_reg[143:96];
    assign m_depth_mean   = o_mean_reg[191:144];
    assign m_color_var    = o_var_reg[47:0];
    assign m_normal_var   = o_var_reg[95:48];
    assign m_texture_var  = o_var_reg[143:96];
    assign m_depth_var    = o_var_reg[191:144];
endmodule
`default_nettype wire

/* tb/sv/per_pixel_welford_stats_core_tb.sv */
// Testbench for per_pixel_welford_stats_core: drives request beats, predicts each
// result with a local Welford store model and checks every result field.
// Depends on pwfs_pkg and the core RTL.
`default_nettype none
module per_pixel_welford_stats_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pwfs_pkg::*;

    // One predicted result beat.
    typedef struct {
        logic [15:0] cnt;
        logic [47:0] mean [4];
        logic [47:0] var_ [4];
    } stats_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = '0;
    logic [5:0] s_pixel_x = '0;
    logic [5:0] s_pixel_y = '0;
    logic [47:0] s_color_sample = '0;
    logic [47:0] s_normal_sample = '0;
    logic [47:0] s_texture_sample = '0;
    logic [47:0] s_depth_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_sample_count;
    logic [47:0] m_color_mean, m_normal_mean, m_texture_mean, m_depth_mean;
    logic [47:0] m_color_var, m_normal_var, m_texture_var, m_depth_var;

    always #2 aclk = ~aclk;

    per_pixel_welford_stats_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .s_color_sample(s_color_sample), .s_normal_sample(s_normal_sample),
        .s_texture_sample(s_texture_sample), .s_depth_sample(s_depth_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_count(m_sample_count),
        .m_color_mean(m_color_mean), .m_normal_mean(m_normal_mean),
        .m_texture_mean(m_texture_mean), .m_depth_mean(m_depth_mean),
        .m_color_var(m_color_var), .m_normal_var(m_normal_var),
        .m_texture_var(m_texture_var), .m_depth_var(m_depth_var)
    );

    // Shadow of the pixel store, kept at the block's widths.
    logic [15:0] shadow_count [NPIX];
    logic [23:0] shadow_mean [NPIX][NCH];
    logic [39:0] shadow_m2 [NPIX][NCH];

    stats_t pending_stats [$];
    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit done = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    // Apply one request to the shadow store and return the expected result.
    function automatic stats_t welford_update(mode_t mode, logic [5:0] px, logic [5:0] py,
                                              logic [47:0] samp [4]);
        stats_t r;
        int p;
        int k;
        logic [31:0] n;
        longint x, om, d, nm, e;
        logic [63:0] prod, m2, v;
        r.cnt = '0;
        for (int f = 0; f < 4; f++) begin
            r.mean[f] = '0;
            r.var_[f] = '0;
        end
        if (px >= IMG_WIDTH || py >= IMG_HEIGHT) return r;
        p = py * IMG_WIDTH + px;
        n = shadow_count[p];
        case (mode)
            MODE_ADD: begin
                if (n < 65535) n++;
                shadow_count[p] = n[15:0];
                for (int c = 0; c < NCH; c++) begin
                    x = longint'($signed(samp[c / 3][16*(c%3) +: 16])) * 256;
                    om = longint'($signed(shadow_mean[p][c]));
                    d = x - om;
                    nm = om + d / longint'(n);
                    e = x - nm;
                    if (d < 0) begin
                        d = -d;
                        e = -e;
                    end
                    prod = (64'(d) * 64'(e)) >> 16;
                    m2 = 64'(shadow_m2[p][c]) + prod;
                    if (m2 > 64'hFF_FFFF_FFFF) m2 = 64'hFF_FFFF_FFFF;
                    shadow_m2[p][c] = m2[39:0];
                    shadow_mean[p][c] = nm[23:0];
                end
            end
            MODE_SETC: begin
                for (int c = 0; c < 3; c++)
                    shadow_mean[p][c] = {samp[0][16*c +: 16], 8'h00};
            end
            MODE_CLEAR: begin
                n = 0;
                shadow_count[p] = '0;
                for (int c = 0; c < NCH; c++) begin
                    shadow_mean[p][c] = '0;
                    shadow_m2[p][c] = '0;
                end
            end
            default: ;
        endcase
        r.cnt = n[15:0];
        for (int c = 0; c < NCH; c++) begin
            k = c % 3;
            r.mean[c / 3][16*k +: 16] = shadow_mean[p][c][23:8];
            v = 0;
            if (n >= 2) begin
                v = 64'(shadow_m2[p][c]) / (64'(n - 1) * 256);
                if (v > 64'hFFFF) v = 64'hFFFF;
            end
            r.var_[c / 3][16*k +: 16] = v[15:0];
        end
        return r;
    endfunction

    // Offer one beat from a falling edge, hold it until accepted, then predict its
    // result. Valid stays up until the next falling edge, where the next call or
    // wait_drained takes it over.
    task automatic send_beat(mode_t mode, logic [5:0] px, logic [5:0] py,
                             logic [47:0] cs, logic [47:0] ns, logic [47:0] ts,
                             logic [47:0] ds);
        logic [47:0] samp [4];
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_pixel_x <= px;
        s_pixel_y <= py;
        s_color_sample <= cs;
        s_normal_sample <= ns;
        s_texture_sample <= ts;
        s_depth_sample <= ds;
        do @(posedge aclk); while (!s_ready);
        samp = '{cs, ns, ts, ds};
        pending_stats.push_back(welford_update(mode, px, py, samp));
    endtask

    function automatic logic [47:0] rand_lanes();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Sample in a small spread around a center so means and variances stay in range.
    function automatic logic [47:0] near_lanes(logic [15:0] ctr);
        logic [47:0] r;
        for (int c = 0; c < 3; c++)
            r[16*c +: 16] = ctr + 16'($urandom_range(1023)) - 16'd512;
        return r;
    endfunction

    // Receiver: stall at random, or hold off for a long stretch on request.
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            stats_t exp_s;
            logic [47:0] got_mean [4];
            logic [47:0] got_var [4];
            bit bad;
            got_mean = '{m_color_mean, m_normal_mean, m_texture_mean, m_depth_mean};
            got_var = '{m_color_var, m_normal_var, m_texture_var, m_depth_var};
            if (pending_stats.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat, count %0d", m_sample_count);
            end else begin
                exp_s = pending_stats.pop_front();
                bad = (exp_s.cnt !== m_sample_count);
                for (int f = 0; f < 4; f++)
                    bad |= (exp_s.mean[f] !== got_mean[f]) || (exp_s.var_[f] !== got_var[f]);
                if (bad) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: count exp %0d got %0d", exp_s.cnt, m_sample_count);
                        for (int f = 0; f < 4; f++)
                            $display("  group %0d mean exp %h got %h var exp %h got %h", f,
                                     exp_s.mean[f], got_mean[f], exp_s.var_[f], got_var[f]);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted beat on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[per_pixel_welford_stats_core] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    // Extremes, every mode, and the corner pixels.
    task automatic test_directed();
        send_beat(MODE_READ, 6'd0, 6'd0, '0, '0, '0, '0);
        send_beat(MODE_ADD, 6'd0, 6'd0, {3{16'h7FFF}}, {3{16'h8000}}, '1, '0);
        send_beat(MODE_ADD, 6'd0, 6'd0, {3{16'h8000}}, {3{16'h7FFF}}, '0, '1);
        send_beat(MODE_ADD, 6'd0, 6'd0, {3{16'h7FFF}}, {3{16'h8000}}, '1, '0);
        send_beat(MODE_READ, 6'd0, 6'd0, '0, '0, '0, '0);
        send_beat(MODE_SETC, 6'd0, 6'd0, 48'h8000_7FFF_1234, '1, '1, '1);
        send_beat(MODE_ADD, 6'd0, 6'd0, 48'h0100_0200_0300, 48'h0001, 48'hFFFF, 48'h0080);
        send_beat(MODE_CLEAR, 6'd0, 6'd0, '1, '1, '1, '1);
        send_beat(MODE_READ, 6'd0, 6'd0, '0, '0, '0, '0);
        send_beat(MODE_ADD, 6'd63, 6'd63, 48'h0001_FFFF_0000, '1, 48'h5555, 48'hAAAA);
        send_beat(MODE_ADD, 6'd63, 6'd63, 48'h0002_FFFE_0001, '0, 48'hAAAA, 48'h5555);
        send_beat(MODE_SETC, 6'd63, 6'd0, '1, '0, '0, '0);
        send_beat(MODE_READ, 6'd63, 6'd0, '0, '0, '0, '0);
        send_beat(MODE_CLEAR, 6'd63, 6'd63, '0, '0, '0, '0);
        wait_drained();
    endtask

    // Accumulation runs on a few hot pixels, mixed with other modes, random pixels and full-range samples.
    task automatic test_random(int items);
        mode_t m;
        logic [5:0] px, py;
        logic [15:0] ctr;
        for (int i = 0; i < items; i++) begin
            px = 6'($urandom_range(3));
            py = 6'($urandom_range(1));
            if ($urandom_range(9) == 0) begin
                px = 6'($urandom);
                py = 6'($urandom);
            end
            m = mode_t'(($urandom_range(9) < 6) ? MODE_ADD : 2'($urandom));
            ctr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
            if ($urandom_range(4) == 0)
                send_beat(m, px, py, rand_lanes(), rand_lanes(), rand_lanes(), rand_lanes());
            else
                send_beat(m, px, py, near_lanes(ctr), near_lanes(ctr), near_lanes(ctr),
                          near_lanes(ctr));
        end
        wait_drained();
    endtask

    // Stop the receiver long enough for the core to back up its input.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_beat(MODE_ADD, 6'd5, 6'd5, near_lanes(16'h0100), rand_lanes(),
                              near_lanes(16'h0000), near_lanes(16'hFF00));
            end
        join
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < NPIX; p++) begin
            shadow_count[p] = '0;
            for (int c = 0; c < NCH; c++) begin
                shadow_mean[p][c] = '0;
                shadow_m2[p][c] = '0;
            end
        end
        test_directed();
        test_backpressure();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(110);
        send_idle_pct = 55; recv_stall_pct = 0;  test_random(110);
        send_idle_pct = 0;  recv_stall_pct = 55; test_random(110);
        send_idle_pct = 28; recv_stall_pct = 28; test_random(110);
        done = 1'b1;
        if (err_count == 0)
            $display("[per_pixel_welford_stats_core] OK");
        else
            $display("[per_pixel_welford_stats_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
